// ===== design/sha1bsh_pkg.sv =====
// Package for the SHA-1 byte stream hasher: controller states, the command
// and status structs between controller and datapath, and SHA-1 constants.
// No dependencies.
package sha1bsh_pkg;

  // Block geometry
  localparam int NUM_DIGEST  = 5;
  localparam int BLOCK_WORDS = 16;
  localparam int ROUNDS      = 80;

  // Initial hash values
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  // Round constants
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  // Padding marker byte
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_LEN,
    ST_LEN_CLR,
    ST_OUT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic byte_wr;     // store a message byte, bump position and length
    logic pad_wr;      // store the 0x80 marker, zero the words after it
    logic len_wr;      // store the bit length in the last two words
    logic len_clear;   // with len_wr: zero words 0..13 as well
    logic comp_start;  // load working vars from hash, clear round count
    logic round_en;    // run one round and shift the schedule
    logic hash_add;    // fold working vars into the hash
    logic out_next;    // advance to the next digest word
    logic reinit;      // back to the start-of-message state
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pos_last;    // next byte fills the block
    logic pad_two;     // marker leaves no room for the length
    logic round_last;  // round 79 in progress
    logic out_last;    // digest word 4 on the output
  } stat_t;

endpackage

// ===== design/sha1bsh_ctrl.sv =====
// Controller for the SHA-1 byte stream hasher: sequences byte intake,
// compression, padding and digest output. Depends on sha1bsh_pkg.
module sha1bsh_ctrl
  import sha1bsh_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  logic  in_tlast,
  input  logic  in_tuser,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;   // where to go after the hash update

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser) begin
            cmd.byte_wr = 1'b1;
            if (stat.pos_last) begin
              cmd.comp_start = 1'b1;
              state_nxt      = ST_ROUND;
              ret_nxt        = in_tlast ? ST_PAD : ST_IDLE;
            end else if (in_tlast) begin
              state_nxt = ST_PAD;
            end
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (stat.round_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.hash_add = 1'b1;
        state_nxt    = ret_r;
      end
      ST_PAD: begin
        cmd.pad_wr = 1'b1;
        if (stat.pad_two) begin
          // no room for the length: compress this block first
          cmd.comp_start = 1'b1;
          state_nxt      = ST_ROUND;
          ret_nxt        = ST_LEN_CLR;
        end else begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN, ST_LEN_CLR: begin
        cmd.len_wr     = 1'b1;
        cmd.len_clear  = (state_r == ST_LEN_CLR);
        cmd.comp_start = 1'b1;
        state_nxt      = ST_ROUND;
        ret_nxt        = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (stat.out_last) begin
            cmd.reinit = 1'b1;
            state_nxt  = ST_IDLE;
            ret_nxt    = ST_IDLE;
          end else begin
            cmd.out_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        ret_nxt   = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/sha1bsh_dp.sv =====
// Datapath for the SHA-1 byte stream hasher: block buffer with rolling
// message schedule, round logic, hash registers and digest output mux.
// Depends on sha1bsh_pkg.
module sha1bsh_dp
  import sha1bsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [7:0]  data_byte,
  output stat_t       stat,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index
);

  logic [31:0] words_r [BLOCK_WORDS];
  logic [31:0] words_nxt [BLOCK_WORDS];
  logic [31:0] wv_r [NUM_DIGEST];
  logic [31:0] h_r [NUM_DIGEST];
  logic [5:0]  pos_r;
  logic [63:0] bitlen_r;
  logic [6:0]  rnd_r;
  logic [2:0]  out_idx_r;

  logic [3:0]  widx;
  logic [1:0]  lane;
  logic [31:0] f_val, k_val, w_cur, w_new, tmp;

  function automatic logic [31:0] put_byte(logic [31:0] w, logic [1:0] ln,
                                           logic [7:0] b);
    logic [31:0] r;
    r = w;
    case (ln)
      2'd0:    r = {b, 24'h0};          // first byte clears the word
      2'd1:    r[23:16] = b;
      2'd2:    r[15:8]  = b;
      2'd3:    r[7:0]   = b;
      default: r = w;
    endcase
    return r;
  endfunction

  assign widx = pos_r[5:2];
  assign lane = pos_r[1:0];

  // Status
  assign stat.pos_last   = (pos_r == 6'd63);
  assign stat.pad_two    = (pos_r >= 6'd56);
  assign stat.round_last = (rnd_r == 7'(ROUNDS - 1));
  assign stat.out_last   = (out_idx_r == 3'(NUM_DIGEST - 1));

  // Round function and constant by round group
  always_comb begin
    if (rnd_r < 7'd20) begin
      f_val = (wv_r[1] & wv_r[2]) | (~wv_r[1] & wv_r[3]);
      k_val = K0;
    end else if (rnd_r < 7'd40) begin
      f_val = wv_r[1] ^ wv_r[2] ^ wv_r[3];
      k_val = K1;
    end else if (rnd_r < 7'd60) begin
      f_val = (wv_r[1] & wv_r[2]) | (wv_r[1] & wv_r[3]) | (wv_r[2] & wv_r[3]);
      k_val = K2;
    end else begin
      f_val = wv_r[1] ^ wv_r[2] ^ wv_r[3];
      k_val = K3;
    end
  end

  // Schedule window: words_r[0] is w[t]; the new word is w[t+16]
  assign w_cur = words_r[0];
  always_comb begin
    logic [31:0] x;
    x     = words_r[13] ^ words_r[8] ^ words_r[2] ^ words_r[0];
    w_new = {x[30:0], x[31]};
  end

  assign tmp = {wv_r[0][26:0], wv_r[0][31:27]} + f_val + wv_r[4] + k_val + w_cur;

  // Block buffer next value
  always_comb begin
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      words_nxt[i] = words_r[i];
    end
    if (cmd.round_en) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        words_nxt[i] = words_r[i + 1];
      end
      words_nxt[BLOCK_WORDS - 1] = w_new;
    end else if (cmd.len_wr) begin
      if (cmd.len_clear) begin
        for (int i = 0; i < BLOCK_WORDS - 2; i++) begin
          words_nxt[i] = '0;
        end
      end
      words_nxt[BLOCK_WORDS - 2] = bitlen_r[63:32];
      words_nxt[BLOCK_WORDS - 1] = bitlen_r[31:0];
    end else if (cmd.pad_wr) begin
      for (int i = 0; i < BLOCK_WORDS; i++) begin
        if (4'(i) == widx) begin
          words_nxt[i] = put_byte(words_r[i], lane, PAD_BYTE);
        end else if (4'(i) > widx) begin
          words_nxt[i] = '0;
        end
      end
    end else if (cmd.byte_wr) begin
      words_nxt[widx] = put_byte(words_r[widx], lane, data_byte);
    end
  end

  // Block buffer, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      words_r[i] <= words_nxt[i];
    end
  end

  // Working variables a..e
  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      for (int i = 0; i < NUM_DIGEST; i++) begin
        wv_r[i] <= h_r[i];
      end
    end else if (cmd.round_en) begin
      wv_r[4] <= wv_r[3];
      wv_r[3] <= wv_r[2];
      wv_r[2] <= {wv_r[1][1:0], wv_r[1][31:2]};
      wv_r[1] <= wv_r[0];
      wv_r[0] <= tmp;
    end
  end

  // Hash, position, length, round and output counters
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      h_r[0]    <= IV0;
      h_r[1]    <= IV1;
      h_r[2]    <= IV2;
      h_r[3]    <= IV3;
      h_r[4]    <= IV4;
      pos_r     <= '0;
      bitlen_r  <= '0;
      rnd_r     <= '0;
      out_idx_r <= '0;
    end else begin
      if (cmd.hash_add) begin
        for (int i = 0; i < NUM_DIGEST; i++) begin
          h_r[i] <= h_r[i] + wv_r[i];
        end
      end
      if (cmd.byte_wr) begin
        pos_r    <= pos_r + 6'd1;
        bitlen_r <= bitlen_r + 64'd8;
      end
      if (cmd.comp_start) begin
        rnd_r <= '0;
      end else if (cmd.round_en) begin
        rnd_r <= rnd_r + 7'd1;
      end
      if (cmd.out_next) begin
        out_idx_r <= out_idx_r + 3'd1;
      end
    end
  end

  // Digest word select
  always_comb begin
    case (out_idx_r)
      3'd0:    digest_word = h_r[0];
      3'd1:    digest_word = h_r[1];
      3'd2:    digest_word = h_r[2];
      3'd3:    digest_word = h_r[3];
      3'd4:    digest_word = h_r[4];
      default: digest_word = h_r[0];
    endcase
  end
  assign word_index = out_idx_r;

endmodule

// ===== design/sha1_byte_stream_hasher_top.sv =====
// Channel  Handshake              Fields (low bit up)
// in       in_tvalid/in_tready    tdata: data_byte[7:0]; tuser: byte_valid; tlast: end_of_message
// out      out_tvalid/out_tready  tdata: digest_word[31:0], word_index[34:32]; tlast: last_word
//
// The byte that fills a 64-byte block holds off input for 80 rounds of one
// shared round unit, then a hash add. An end transfer is followed by one
// padding step, one length step and the compression of one or two blocks,
// each of 80 rounds and a hash add, then by five output transfers.
// Reset is synchronous on rst_n; output stalls simply hold the current digest
// word, and input is taken again after word 4.
//
// Top level of the SHA-1 byte stream hasher: ties the controller to the
// datapath. Depends on sha1bsh_pkg, sha1bsh_ctrl and sha1bsh_dp.
module sha1_byte_stream_hasher_top
  import sha1bsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tuser,   // byte_valid
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word[31:0], word_index[34:32], zero fill
  output logic        out_tlast   // last_word
);

  cmd_t        cmd;
  stat_t       stat;
  logic [31:0] digest_word;
  logic [2:0]  word_index;

  sha1bsh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sha1bsh_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_tdata),
    .stat        (stat),
    .digest_word (digest_word),
    .word_index  (word_index)
  );

  // Output packing
  assign out_tdata = {5'b0, word_index, digest_word};
  assign out_tlast = stat.out_last;

endmodule
